### hw/rtl/arpc_pkg.sv
// Package for the ARP cache block: widths, status and kind codes, register indexes.
// No dependencies.
package arpc_pkg;
    localparam int CacheEntries   = 16;
    localparam int PendingEntries = 16;
    localparam int IpW  = 32;
    localparam int MacW = 48;
    localparam int AddrW = 4;

    localparam logic [1:0] KindLookup = 2'd0;
    localparam logic [1:0] KindReply  = 2'd1;
    localparam logic [1:0] KindTick   = 2'd2;
    localparam logic [1:0] KindUnused = 2'd3;

    localparam logic [2:0] StHit      = 3'd0;
    localparam logic [2:0] StWaiting  = 3'd1;
    localparam logic [2:0] StSend     = 3'd2;
    localparam logic [2:0] StUnreach  = 3'd3;
    localparam logic [2:0] StResolved = 3'd4;
    localparam logic [2:0] StStored   = 3'd5;
    localparam logic [2:0] StPendFull = 3'd6;
    localparam logic [2:0] StTickDone = 3'd7;

    localparam logic [AddrW-1:0] RegTimeout = 4'd0;
    localparam logic [AddrW-1:0] RegRetry   = 4'd4;
    localparam logic [AddrW-1:0] RegGap     = 4'd8;

    typedef struct packed {
        logic [1:0]      kind;
        logic [IpW-1:0]  ip_addr;
        logic [MacW-1:0] mac_addr;
    } t_req;

    typedef struct packed {
        logic [2:0]      status;
        logic [IpW-1:0]  ip_addr_out;
        logic [MacW-1:0] mac_addr_out;
        logic            stored;
        logic            last;
    } t_rsp;
endpackage

### hw/rtl/arpc_if.sv
// Valid/ready channel interface carrying one payload type.
// Depends on arpc_pkg for the payload structs.
interface arpc_req_if;
    logic            valid;
    logic            ready;
    arpc_pkg::t_req  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface arpc_rsp_if;
    logic            valid;
    logic            ready;
    arpc_pkg::t_rsp  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/arp_cache_with_request_retry.sv
// ARP cache with pending-request retry: one shared compare/update unit walks slots.
// A missed lookup and a tick walk the cache, then the pending slots; a reply walks them
// in the other order; a lookup hit skips the pending walk. A held output stalls the tick walk.
// Throughput: one item in flight; ready returns the cycle after the last transaction leaves.
// Reset (i_rst_n low, synchronous): valid bits cleared, registers to 15/5/1, idle.
// Depends on arpc_pkg and the channel interfaces in arpc_if.sv.
module arp_cache_with_request_retry #(
    parameter int CACHE_ENTRIES   = arpc_pkg::CacheEntries,
    parameter int PENDING_ENTRIES = arpc_pkg::PendingEntries
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    arpc_req_if.sink                s_in,
    arpc_rsp_if.source              m_out,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [arpc_pkg::AddrW-1:0] paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    localparam int CW = $clog2(CACHE_ENTRIES);
    localparam int PW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CSCAN = 3'd1; // cache walk (lookup hit / reply free / tick aging)
    localparam logic [2:0] S_PSCAN = 3'd2; // pending walk
    localparam logic [2:0] S_DONE  = 3'd3; // decide and emit final transaction
    localparam logic [2:0] S_EMIT  = 3'd4; // waiting for output to drain

    // config registers
    logic [7:0] r_timeout, r_gap;
    logic [3:0] r_retry;

    // storage
    logic [CACHE_ENTRIES-1:0]   r_ev;
    logic [arpc_pkg::IpW-1:0]   r_eip  [CACHE_ENTRIES];
    logic [arpc_pkg::MacW-1:0]  r_emac [CACHE_ENTRIES];
    logic [7:0]                 r_eage [CACHE_ENTRIES];
    logic [PENDING_ENTRIES-1:0] r_pv;
    logic [arpc_pkg::IpW-1:0]   r_pip  [PENDING_ENTRIES];
    logic [7:0]                 r_psince [PENDING_ENTRIES];
    logic [3:0]                 r_ptries [PENDING_ENTRIES];

    // sequencer
    logic [2:0]          r_state;
    arpc_pkg::t_req      r_req;
    logic [CW:0]         r_ci;
    logic [PW:0]         r_pi;
    logic                r_hit, r_cfree, r_pend, r_pfree;
    logic [CW-1:0]       r_hit_i, r_cfree_i;
    logic [PW-1:0]       r_pend_i, r_pfree_i;
    logic                r_waiter;
    logic                r_ovalid;
    arpc_pkg::t_rsp      r_odata;

    assign pready = 1'b1;
    always_comb begin
        unique case (paddr)
            arpc_pkg::RegTimeout: prdata = {24'd0, r_timeout};
            arpc_pkg::RegRetry:   prdata = {28'd0, r_retry};
            arpc_pkg::RegGap:     prdata = {24'd0, r_gap};
            default:              prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= 8'd15;
            r_retry   <= 4'd5;
            r_gap     <= 8'd1;
        end else if (psel && penable && pwrite) begin
            if (paddr == arpc_pkg::RegTimeout) r_timeout <= pwdata[7:0];
            if (paddr == arpc_pkg::RegRetry)   r_retry   <= pwdata[3:0];
            if (paddr == arpc_pkg::RegGap)     r_gap     <= pwdata[7:0];
        end
    end

    assign s_in.ready   = (r_state == S_IDLE);
    assign m_out.valid  = r_ovalid;
    assign m_out.data   = r_odata;

    wire [CW-1:0] ci = r_ci[CW-1:0];
    wire [PW-1:0] pi = r_pi[PW-1:0];

    // shared compare unit
    wire ceq = (r_eip[ci] == r_req.ip_addr);
    wire peq = (r_pip[pi] == r_req.ip_addr);
    wire [8:0] age_inc   = {1'b0, r_eage[ci]} + 9'd1;
    wire [8:0] since_inc = {1'b0, r_psince[pi]} + 9'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ev     <= '0;
            r_pv     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_in.valid) begin
                        r_req   <= s_in.data;
                        r_ci    <= '0;
                        r_pi    <= '0;
                        r_hit   <= 1'b0;
                        r_cfree <= 1'b0;
                        r_pend  <= 1'b0;
                        r_pfree <= 1'b0;
                        r_waiter <= 1'b0;
                        if (s_in.data.kind == arpc_pkg::KindReply)
                            r_state <= S_PSCAN;
                        else if (s_in.data.kind != arpc_pkg::KindUnused)
                            r_state <= S_CSCAN;
                    end
                end
                S_CSCAN: begin
                    if (r_ev[ci]) begin
                        if (r_req.kind == arpc_pkg::KindTick) begin
                            if (age_inc > {1'b0, r_timeout}) r_ev[ci] <= 1'b0;
                            r_eage[ci] <= age_inc[8] ? 8'hFF : age_inc[7:0];
                        end else if (ceq) begin
                            r_hit   <= 1'b1;
                            r_hit_i <= ci;
                        end
                    end else if (!r_cfree) begin
                        r_cfree   <= 1'b1;
                        r_cfree_i <= ci;
                    end
                    r_ci <= r_ci + 1'b1;
                    if (r_ci == (CW+1)'(CACHE_ENTRIES - 1)) begin
                        if (r_req.kind == arpc_pkg::KindLookup && !(r_ev[ci] && ceq) && !r_hit)
                            r_state <= S_PSCAN;
                        else if (r_req.kind == arpc_pkg::KindTick)
                            r_state <= S_PSCAN;
                        else
                            r_state <= S_DONE;
                    end
                end
                S_PSCAN: begin
                    if (r_req.kind == arpc_pkg::KindTick) begin
                        if (!r_ovalid || m_out.ready) begin
                            if (r_pv[pi] && since_inc > {1'b0, r_gap}) begin
                                r_ovalid <= 1'b1;
                                r_odata.ip_addr_out  <= r_pip[pi];
                                r_odata.mac_addr_out <= '0;
                                r_odata.stored <= 1'b0;
                                r_odata.last   <= 1'b0;
                                if (r_ptries[pi] >= r_retry) begin
                                    r_pv[pi] <= 1'b0;
                                    r_psince[pi] <= since_inc[8] ? 8'hFF : since_inc[7:0];
                                    r_odata.status <= arpc_pkg::StUnreach;
                                end else begin
                                    r_psince[pi] <= 8'd0;
                                    r_ptries[pi] <= r_ptries[pi] + 4'd1;
                                    r_odata.status <= arpc_pkg::StSend;
                                end
                            end else begin
                                r_ovalid <= 1'b0;
                                if (r_pv[pi])
                                    r_psince[pi] <= since_inc[8] ? 8'hFF : since_inc[7:0];
                            end
                            r_pi <= r_pi + 1'b1;
                            if (r_pi == (PW+1)'(PENDING_ENTRIES - 1)) r_state <= S_DONE;
                        end
                    end else begin
                        if (r_pv[pi] && peq) begin
                            if (r_req.kind == arpc_pkg::KindReply) begin
                                r_pv[pi] <= 1'b0;
                                r_waiter <= 1'b1;
                            end else if (!r_pend) begin
                                r_pend   <= 1'b1;
                                r_pend_i <= pi;
                            end
                        end
                        if (!r_pv[pi] && !r_pfree) begin
                            r_pfree   <= 1'b1;
                            r_pfree_i <= pi;
                        end
                        r_pi <= r_pi + 1'b1;
                        // reply walks the cache for a free slot after the pending walk
                        if (r_pi == (PW+1)'(PENDING_ENTRIES - 1))
                            r_state <= (r_req.kind == arpc_pkg::KindReply) ? S_CSCAN : S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || m_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_odata.ip_addr_out <= (r_req.kind == arpc_pkg::KindTick) ?
                                               '0 : r_req.ip_addr;
                        r_odata.stored <= (r_req.kind == arpc_pkg::KindReply) && r_cfree;
                        r_odata.last   <= 1'b1;
                        r_state <= S_EMIT;
                        unique case (r_req.kind)
                            arpc_pkg::KindTick: begin
                                r_odata.status       <= arpc_pkg::StTickDone;
                                r_odata.mac_addr_out <= '0;
                            end
                            arpc_pkg::KindReply: begin
                                if (r_cfree) begin
                                    r_ev[r_cfree_i]   <= 1'b1;
                                    r_eip[r_cfree_i]  <= r_req.ip_addr;
                                    r_emac[r_cfree_i] <= r_req.mac_addr;
                                    r_eage[r_cfree_i] <= 8'd0;
                                end
                                if (r_waiter) begin
                                    r_odata.status       <= arpc_pkg::StResolved;
                                    r_odata.mac_addr_out <= r_req.mac_addr;
                                end else begin
                                    r_odata.status       <= arpc_pkg::StStored;
                                    r_odata.mac_addr_out <= '0;
                                end
                            end
                            default: begin
                                if (r_hit) begin
                                    r_odata.status       <= arpc_pkg::StHit;
                                    r_odata.mac_addr_out <= r_emac[r_hit_i];
                                end else begin
                                    r_odata.mac_addr_out <= '0;
                                    if (r_pend) begin
                                        if (r_psince[r_pend_i] > r_gap) begin
                                            if (r_ptries[r_pend_i] >= r_retry) begin
                                                r_pv[r_pend_i] <= 1'b0;
                                                r_odata.status <= arpc_pkg::StUnreach;
                                            end else begin
                                                r_psince[r_pend_i] <= 8'd0;
                                                r_ptries[r_pend_i] <= r_ptries[r_pend_i] + 4'd1;
                                                r_odata.status <= arpc_pkg::StSend;
                                            end
                                        end else begin
                                            r_odata.status <= arpc_pkg::StWaiting;
                                        end
                                    end else if (r_pfree) begin
                                        r_pip[r_pfree_i] <= r_req.ip_addr;
                                        r_psince[r_pfree_i] <= 8'd0;
                                        if (r_retry == 4'd0) begin
                                            r_odata.status <= arpc_pkg::StUnreach;
                                        end else begin
                                            r_pv[r_pfree_i]     <= 1'b1;
                                            r_ptries[r_pfree_i] <= 4'd1;
                                            r_odata.status <= arpc_pkg::StSend;
                                        end
                                    end else begin
                                        r_odata.status <= arpc_pkg::StPendFull;
                                    end
                                end
                            end
                        endcase
                    end
                end
                S_EMIT: begin
                    if (r_ovalid && m_out.ready) begin
                        r_ovalid <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### hw/rtl/arpc_checker.sv
// Port-level checker for the ARP cache block, bound to the top level.
// Depends on arpc_pkg and the channel interfaces.
module arpc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] in_kind,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] out_status,
    input logic       out_last
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid) else $error("output dropped");
    a_tick_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_status == arpc_pkg::StTickDone |-> out_last)
        else $error("tick done not last");
    // unknown kinds are taken and dropped without leaving idle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && in_kind != arpc_pkg::KindUnused |=> !in_ready)
        else $error("accepted while busy");
endmodule

bind arp_cache_with_request_retry arpc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(s_in.valid), .in_ready(s_in.ready), .in_kind(s_in.data.kind),
    .out_valid(m_out.valid), .out_ready(m_out.ready),
    .out_status(m_out.data.status), .out_last(m_out.data.last)
);
